>>> rtl/core/hrsp_pkg.sv
package hrsp_pkg;

  localparam int unsigned LEN_W   = 10;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W  = $clog2(QUEUE_DEPTH + 1);

  localparam logic [LEN_W-1:0] LEN_MAX        = 10'd1023;
  localparam logic [LEN_W-1:0] MIN_LEN        = 10'd11;
  localparam logic [LEN_W-1:0] POS_COUNT      = 10'd2;
  localparam logic [LEN_W-1:0] POS_ADDR_HI    = 10'd4;
  localparam logic [LEN_W-1:0] POS_ADDR_LO    = 10'd6;
  localparam logic [LEN_W-1:0] POS_TYPE       = 10'd8;
  localparam logic [LEN_W-1:0] POS_DATA_FIRST = 10'd10;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam logic [7:0] TYPE_DATA = 8'h00;
  localparam logic [7:0] TYPE_EOF  = 8'h01;
  localparam logic [7:0] TYPE_MAX  = 8'h05;

  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_EOF    = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_PREFIX   = 3'd1;
  localparam logic [2:0] ERR_LENGTH   = 3'd2;
  localparam logic [2:0] ERR_NONHEX   = 3'd3;
  localparam logic [2:0] ERR_MISMATCH = 3'd4;
  localparam logic [2:0] ERR_CHECKSUM = 3'd5;
  localparam logic [2:0] ERR_TYPE     = 3'd6;
  localparam logic [2:0] ERR_NO_EOF   = 3'd7;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [15:0] record_address;
    logic [7:0]  byte_index;
    logic [7:0]  data_value;
    logic [2:0]  record_kind;
    logic [2:0]  error_code;
    logic        last_of_run;
  } result_t;

endpackage

>>> rtl/core/hrsp_in_if.sv
interface hrsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_input;

  modport source (output valid, output char_in, output end_of_input, input ready);
  modport sink (input valid, input char_in, input end_of_input, output ready);
endinterface

>>> rtl/core/hrsp_out_if.sv
interface hrsp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [15:0] record_address;
  logic [7:0]  byte_index;
  logic [7:0]  data_value;
  logic [2:0]  record_kind;
  logic [2:0]  error_code;
  logic        last_of_run;

  modport source (
    output valid, output result_kind, output record_address, output byte_index,
    output data_value, output record_kind, output error_code, output last_of_run,
    input ready
  );
  modport sink (
    input valid, input result_kind, input record_address, input byte_index,
    input data_value, input record_kind, input error_code, input last_of_run,
    output ready
  );
endinterface

>>> rtl/core/hrsp_queue.sv
module hrsp_queue import hrsp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [1:0]  push_count,
  input  result_t     push_first,
  input  result_t     push_second,
  output logic        has_room,
  hrsp_out_if.source  out_ch
);

  result_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic [QCNT_W-1:0]   count_next;
  logic                pop;
  logic [QPTR_W-1:0]   wr_ptr_plus;
  result_t             head;

  assign pop         = out_ch.valid && out_ch.ready;
  assign wr_ptr_plus = wr_ptr + QPTR_W'(1);
  assign has_room    = count <= QCNT_W'(QUEUE_DEPTH - 2);
  assign count_next  = count + QCNT_W'(push_count) - QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push_count);
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      slots[wr_ptr] <= push_first;
    end
    if (push_count == 2'd2) begin
      slots[wr_ptr_plus] <= push_second;
    end
  end

  assign head                  = slots[rd_ptr];
  assign out_ch.valid          = count != '0;
  assign out_ch.result_kind    = head.result_kind;
  assign out_ch.record_address = head.record_address;
  assign out_ch.byte_index     = head.byte_index;
  assign out_ch.data_value     = head.data_value;
  assign out_ch.record_kind    = head.record_kind;
  assign out_ch.error_code     = head.error_code;
  assign out_ch.last_of_run    = head.last_of_run;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("result queue overflow");

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    push_count != 2'd0 |-> has_room)
    else $error("push into full result queue");

endmodule

>>> rtl/core/hex_record_stream_parser.sv
// Hex-record line parser, one ASCII character per request on in_ch, results on
// out_ch. A character is taken every cycle while the four-entry result queue has
// at least two free slots, so the parser runs at one character per clock as long
// as out_ch drains; a result leaves the queue the cycle after its character at the
// earliest. Data bytes of type-0 records come out as provisional results as soon as
// their pair is decoded; the line end gives accept, EOF record or the first error.
// An end_of_input request may yield two results (line close, then missing EOF).
// After an error or an EOF record, all further requests are taken and dropped.
module hex_record_stream_parser import hrsp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  hrsp_in_if.sink    in_ch,
  hrsp_out_if.source out_ch
);

  logic [LEN_W-1:0] line_length, line_length_next;
  logic             length_parity, length_parity_next;
  logic             space_run_pending, space_run_pending_next;
  logic [LEN_W-1:0] space_run_start, space_run_start_next;
  logic             run_parity, run_parity_next;
  logic [3:0]       high_nibble, high_nibble_next;
  logic             pair_has_bad_char, pair_has_bad_char_next;
  logic [7:0]       count_field, count_field_next;
  logic [15:0]      address_field, address_field_next;
  logic [7:0]       type_field, type_field_next;
  logic [7:0]       byte_sum, byte_sum_next;
  logic             prefix_bad, prefix_bad_next;
  logic             header_bad_char, header_bad_char_next;
  logic             any_bad_char, any_bad_char_next;
  logic             stream_finished, stream_finished_next;
  logic             stream_failed, stream_failed_next;

  logic        has_room;
  logic        accept, active;
  logic [7:0]  c;
  logic        eoi, is_lf, is_ws;
  logic [4:0]  nib;
  logic        ok;
  logic [LEN_W-1:0] pos;
  logic [LEN_W-1:0] len_inc;
  logic        pos_zero;
  logic        prefix_bad_tc, header_bad_tc, any_bad_tc;
  logic        pair_bad_even, pair_take;
  logic [7:0]  b;
  logic [LEN_W-1:0] pos_m10;
  logic [8:0]  k;
  logic        emit;
  logic [LEN_W-1:0] fin_len, fin_expect;
  logic        fin_par, fin_nonzero, fin_eof;
  logic [2:0]  fin_err;
  result_t     fin_res, data_res, e7_res, r0, r1;
  logic [1:0]  push_count;

  function automatic logic [4:0] nibble_of(input logic [7:0] ch);
    logic [4:0] v;
    v = 5'd16;
    if (ch >= 8'h30 && ch <= 8'h39) v = 5'(ch - 8'h30);
    else if (ch >= 8'h41 && ch <= 8'h46) v = 5'(ch - 8'h37);
    else if (ch >= 8'h61 && ch <= 8'h66) v = 5'(ch - 8'h57);
    return v;
  endfunction

  assign in_ch.ready = has_room;
  assign accept = in_ch.valid && in_ch.ready;
  assign active = accept && !stream_finished && !stream_failed;
  assign c      = in_ch.char_in;
  assign eoi    = in_ch.end_of_input;
  assign is_lf  = c == CHAR_LF;
  assign is_ws  = c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_CR;
  assign nib    = nibble_of(c);
  assign ok     = !nib[4];
  assign pos    = line_length;
  assign pos_zero = pos == '0;
  assign len_inc  = (line_length == LEN_MAX) ? line_length : line_length + LEN_W'(1);

  assign prefix_bad_tc = prefix_bad || (space_run_pending && space_run_start == '0)
                      || (pos_zero && c != CHAR_COLON);
  assign header_bad_tc = header_bad_char
                      || (space_run_pending && space_run_start <= POS_TYPE && pos >= POS_COUNT)
                      || (!pos_zero && !ok && pos <= POS_TYPE);
  assign any_bad_tc    = any_bad_char || space_run_pending || (!pos_zero && !ok);
  assign pair_bad_even = pair_has_bad_char || space_run_pending || !ok;
  assign pair_take     = !pos_zero && !length_parity && !pair_bad_even;
  assign b             = {high_nibble, nib[3:0]};
  assign pos_m10       = pos - POS_DATA_FIRST;
  assign k             = pos_m10[LEN_W-1:1];
  assign emit = pair_take && pos >= POS_DATA_FIRST && pos < LEN_MAX
             && type_field == TYPE_DATA && !prefix_bad_tc && !header_bad_tc
             && {1'b0, count_field} > k;

  assign fin_len     = space_run_pending ? space_run_start : line_length;
  assign fin_par     = length_parity ^ run_parity;
  assign fin_nonzero = fin_len != '0;
  assign fin_expect  = MIN_LEN + {1'b0, count_field, 1'b0};

  always_comb begin
    fin_err = ERR_NONE;
    priority if (prefix_bad)                           fin_err = ERR_PREFIX;
    else if (fin_len < MIN_LEN || !fin_par)           fin_err = ERR_LENGTH;
    else if (header_bad_char)                          fin_err = ERR_NONHEX;
    else if (fin_len != fin_expect)                    fin_err = ERR_MISMATCH;
    else if (any_bad_char)                             fin_err = ERR_NONHEX;
    else if (byte_sum != 8'h00)                        fin_err = ERR_CHECKSUM;
    else if (type_field > TYPE_MAX)                    fin_err = ERR_TYPE;
    else                                               fin_err = ERR_NONE;
  end

  assign fin_eof = fin_nonzero && fin_err == ERR_NONE && type_field == TYPE_EOF;

  always_comb begin
    fin_res = '0;
    if (fin_err != ERR_NONE) begin
      fin_res.result_kind = KIND_ERROR;
      fin_res.error_code  = fin_err;
    end else begin
      fin_res.result_kind    = (type_field == TYPE_EOF) ? KIND_EOF : KIND_ACCEPT;
      fin_res.record_address = address_field;
      fin_res.record_kind    = type_field[2:0];
    end
    data_res                = '0;
    data_res.result_kind    = KIND_DATA;
    data_res.record_address = address_field;
    data_res.byte_index     = k[7:0];
    data_res.data_value     = b;
    e7_res                  = '0;
    e7_res.result_kind      = KIND_ERROR;
    e7_res.error_code       = ERR_NO_EOF;
  end

  always_comb begin
    push_count = 2'd0;
    r0 = '0;
    r1 = '0;
    if (active) begin
      priority if (eoi) begin
        if (fin_nonzero) begin
          r0 = fin_res;
          if (fin_err == ERR_NONE && !fin_eof) begin
            r1 = e7_res;
            push_count = 2'd2;
          end else begin
            push_count = 2'd1;
          end
        end else begin
          r0 = e7_res;
          push_count = 2'd1;
        end
      end else if (is_lf) begin
        if (fin_nonzero) begin
          r0 = fin_res;
          push_count = 2'd1;
        end
      end else if (is_ws) begin
        push_count = 2'd0;
      end else begin
        if (emit) begin
          r0 = data_res;
          push_count = 2'd1;
        end
      end
    end
    if (push_count == 2'd1) r0.last_of_run = 1'b1;
    if (push_count == 2'd2) r1.last_of_run = 1'b1;
  end

  always_comb begin
    line_length_next       = line_length;
    length_parity_next     = length_parity;
    space_run_pending_next = space_run_pending;
    space_run_start_next   = space_run_start;
    run_parity_next        = run_parity;
    high_nibble_next       = high_nibble;
    pair_has_bad_char_next = pair_has_bad_char;
    count_field_next       = count_field;
    address_field_next     = address_field;
    type_field_next        = type_field;
    byte_sum_next          = byte_sum;
    prefix_bad_next        = prefix_bad;
    header_bad_char_next   = header_bad_char;
    any_bad_char_next      = any_bad_char;
    stream_finished_next   = stream_finished;
    stream_failed_next     = stream_failed;
    if (active) begin
      priority if (eoi || is_lf) begin
        line_length_next       = '0;
        length_parity_next     = 1'b0;
        space_run_pending_next = 1'b0;
        space_run_start_next   = '0;
        run_parity_next        = 1'b0;
        high_nibble_next       = '0;
        pair_has_bad_char_next = 1'b0;
        count_field_next       = '0;
        address_field_next     = '0;
        type_field_next        = '0;
        byte_sum_next          = '0;
        prefix_bad_next        = 1'b0;
        header_bad_char_next   = 1'b0;
        any_bad_char_next      = 1'b0;
        if (fin_eof) begin
          stream_finished_next = 1'b1;
        end else if (eoi || (fin_nonzero && fin_err != ERR_NONE)) begin
          stream_failed_next = 1'b1;
        end
      end else if (is_ws) begin
        if (!space_run_pending) begin
          space_run_start_next = line_length;
        end
        space_run_pending_next = 1'b1;
        run_parity_next        = space_run_pending ? !run_parity : 1'b1;
        line_length_next       = len_inc;
        length_parity_next     = !length_parity;
      end else begin
        space_run_pending_next = 1'b0;
        run_parity_next        = 1'b0;
        prefix_bad_next        = prefix_bad_tc;
        header_bad_char_next   = header_bad_tc;
        any_bad_char_next      = any_bad_tc;
        if (pos_zero) begin
          pair_has_bad_char_next = pair_has_bad_char || (space_run_pending && !length_parity);
        end else if (length_parity) begin
          pair_has_bad_char_next = !ok;
          high_nibble_next       = ok ? nib[3:0] : 4'd0;
        end else begin
          pair_has_bad_char_next = 1'b0;
          if (pair_take) begin
            byte_sum_next = byte_sum + b;
            priority if (pos == POS_COUNT)   count_field_next = b;
            else if (pos == POS_ADDR_HI)     address_field_next = {b, address_field[7:0]};
            else if (pos == POS_ADDR_LO)     address_field_next = {address_field[15:8], b};
            else if (pos == POS_TYPE)        type_field_next = b;
            else                             byte_sum_next = byte_sum + b;
          end
        end
        line_length_next   = len_inc;
        length_parity_next = !length_parity;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length       <= '0;
      length_parity     <= 1'b0;
      space_run_pending <= 1'b0;
      space_run_start   <= '0;
      run_parity        <= 1'b0;
      high_nibble       <= '0;
      pair_has_bad_char <= 1'b0;
      count_field       <= '0;
      address_field     <= '0;
      type_field        <= '0;
      byte_sum          <= '0;
      prefix_bad        <= 1'b0;
      header_bad_char   <= 1'b0;
      any_bad_char      <= 1'b0;
      stream_finished   <= 1'b0;
      stream_failed     <= 1'b0;
    end else begin
      line_length       <= line_length_next;
      length_parity     <= length_parity_next;
      space_run_pending <= space_run_pending_next;
      space_run_start   <= space_run_start_next;
      run_parity        <= run_parity_next;
      high_nibble       <= high_nibble_next;
      pair_has_bad_char <= pair_has_bad_char_next;
      count_field       <= count_field_next;
      address_field     <= address_field_next;
      type_field        <= type_field_next;
      byte_sum          <= byte_sum_next;
      prefix_bad        <= prefix_bad_next;
      header_bad_char   <= header_bad_char_next;
      any_bad_char      <= any_bad_char_next;
      stream_finished   <= stream_finished_next;
      stream_failed     <= stream_failed_next;
    end
  end

  hrsp_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push_count  (push_count),
    .push_first  (r0),
    .push_second (r1),
    .has_room    (has_room),
    .out_ch      (out_ch)
  );

  a_done_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(stream_finished && stream_failed))
    else $error("stream both finished and failed");

  a_done_silent: assert property (@(posedge clk) disable iff (rst)
    (stream_finished || stream_failed) |-> push_count == 2'd0)
    else $error("result produced after stream end");

  a_pair_only_at_end: assert property (@(posedge clk) disable iff (rst)
    push_count == 2'd2 |-> accept && eoi)
    else $error("two results from a non-terminal request");

  a_end_is_sticky: assert property (@(posedge clk) disable iff (rst)
    (accept && eoi) |=> stream_finished || stream_failed)
    else $error("end of input did not close the stream");

endmodule

>>> tb/hrsp_record_checker.sv
`timescale 1ns / 100ps

module hrsp_record_checker import hrsp_pkg::*; (
  input  logic clk,
  input  logic rst,
  hrsp_in_if   in_mon,
  hrsp_out_if  out_mon,
  output int   error_count,
  output int   pending_count
);

  result_t expected_results[$];

  logic [9:0]  line_len;
  logic [9:0]  ws_run;
  logic [9:0]  ws_start;
  bit          len_par;
  bit          ws_par;
  logic [3:0]  hi_nib;
  bit          pair_bad;
  logic [7:0]  cnt;
  logic [15:0] addr;
  logic [7:0]  typ;
  logic [7:0]  sum;
  bit          pfx_bad;
  bit          hdr_bad;
  bit          any_bad;
  bit          stream_done;
  bit          stream_failed;

  function automatic logic [9:0] sat_inc(logic [9:0] x);
    return (x == LEN_MAX) ? x : x + 10'd1;
  endfunction

  function automatic logic [4:0] nibble_of(logic [7:0] c);
    if (c >= "0" && c <= "9") return 5'(c - "0");
    if (c >= "A" && c <= "F") return 5'(c - "A" + 8'd10);
    if (c >= "a" && c <= "f") return 5'(c - "a" + 8'd10);
    return 5'd16;
  endfunction

  function automatic void emit(logic [1:0] kind, logic [15:0] a, logic [7:0] idx,
                               logic [7:0] val, logic [2:0] rk, logic [2:0] err);
    result_t r;
    r.result_kind    = kind;
    r.record_address = a;
    r.byte_index     = idx;
    r.data_value     = val;
    r.record_kind    = rk;
    r.error_code     = err;
    r.last_of_run    = 1'b0;
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic void clear_line();
    line_len = '0;
    ws_run   = '0;
    ws_start = '0;
    len_par  = 1'b0;
    ws_par   = 1'b0;
    hi_nib   = '0;
    pair_bad = 1'b0;
    cnt      = '0;
    addr     = '0;
    typ      = '0;
    sum      = '0;
    pfx_bad  = 1'b0;
    hdr_bad  = 1'b0;
    any_bad  = 1'b0;
  endfunction

  function automatic void close_line();
    logic [9:0]  len;
    bit          par;
    logic [2:0]  err;
    logic [7:0]  t;
    logic [15:0] a;
    len = (ws_run != 0) ? ws_start : line_len;
    par = len_par ^ ws_par;
    err = ERR_NONE;
    t   = typ;
    a   = addr;
    if (len == 0) begin
      clear_line();
      return;
    end
    if (pfx_bad) err = ERR_PREFIX;
    else if (len < MIN_LEN || !par) err = ERR_LENGTH;
    else if (hdr_bad) err = ERR_NONHEX;
    else if (int'(len) != int'(MIN_LEN) + 2 * int'(cnt)) err = ERR_MISMATCH;
    else if (any_bad) err = ERR_NONHEX;
    else if (sum != 8'd0) err = ERR_CHECKSUM;
    else if (t > TYPE_MAX) err = ERR_TYPE;
    clear_line();
    if (err != ERR_NONE) begin
      stream_failed = 1'b1;
      emit(KIND_ERROR, 16'd0, 8'd0, 8'd0, 3'd0, err);
    end else if (t == TYPE_EOF) begin
      stream_done = 1'b1;
      emit(KIND_EOF, a, 8'd0, 8'd0, t[2:0], ERR_NONE);
    end else begin
      emit(KIND_ACCEPT, a, 8'd0, 8'd0, t[2:0], ERR_NONE);
    end
  endfunction

  function automatic void take_char(logic [7:0] c);
    logic [9:0] pos;
    bit         odd;
    logic [4:0] nib;
    bit         ok;
    logic [7:0] b;
    int         k;
    pos = line_len;
    odd = len_par;
    if (ws_run != 0) begin
      if (ws_start == 0) pfx_bad = 1'b1;
      if (ws_start <= POS_TYPE && pos >= POS_COUNT) hdr_bad = 1'b1;
      any_bad = 1'b1;
      if (!odd) pair_bad = 1'b1;
      ws_run = '0;
      ws_par = 1'b0;
    end
    if (pos == 0) begin
      if (c != CHAR_COLON) pfx_bad = 1'b1;
    end else begin
      nib = nibble_of(c);
      ok  = !nib[4];
      if (!ok) begin
        any_bad = 1'b1;
        if (pos <= POS_TYPE) hdr_bad = 1'b1;
      end
      if (odd) begin
        pair_bad = !ok;
        hi_nib   = ok ? nib[3:0] : 4'd0;
      end else begin
        if (!ok) pair_bad = 1'b1;
        if (!pair_bad) begin
          b   = {hi_nib, nib[3:0]};
          sum = sum + b;
          if (pos == POS_COUNT) cnt = b;
          else if (pos == POS_ADDR_HI) addr[15:8] = b;
          else if (pos == POS_ADDR_LO) addr[7:0] = b;
          else if (pos == POS_TYPE) typ = b;
          else if (pos >= POS_DATA_FIRST && pos < LEN_MAX && typ == TYPE_DATA &&
                   !pfx_bad && !hdr_bad) begin
            k = int'(pos - POS_DATA_FIRST) >> 1;
            if (k < int'(cnt)) emit(KIND_DATA, addr, k[7:0], b, 3'd0, ERR_NONE);
          end
        end
        pair_bad = 1'b0;
      end
    end
    line_len = sat_inc(line_len);
    len_par  = !len_par;
  endfunction

  function automatic void parse_char(logic [7:0] c, logic eoi);
    int      n_before;
    result_t r;
    n_before = expected_results.size();
    if (stream_done || stream_failed) return;
    if (eoi) begin
      close_line();
      if (!stream_done && !stream_failed) begin
        stream_failed = 1'b1;
        emit(KIND_ERROR, 16'd0, 8'd0, 8'd0, 3'd0, ERR_NO_EOF);
      end
    end else if (c == CHAR_LF) begin
      close_line();
    end else if (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_CR) begin
      if (ws_run == 0) begin
        ws_start = line_len;
        ws_par   = 1'b0;
      end
      ws_run   = sat_inc(ws_run);
      ws_par   = !ws_par;
      line_len = sat_inc(line_len);
      len_par  = !len_par;
    end else begin
      take_char(c);
    end
    if (expected_results.size() > n_before) begin
      r = expected_results[expected_results.size() - 1];
      r.last_of_run = 1'b1;
      expected_results[expected_results.size() - 1] = r;
    end
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] seen);
    if (seen !== want) begin
      $error("%s: expected %0h, got %0h", name, want, seen);
      error_count++;
    end
  endfunction

  function automatic void check_result();
    result_t want;
    if (expected_results.size() == 0) begin
      $error("unexpected result: kind %0d, address %0h, error code %0d",
             out_mon.result_kind, out_mon.record_address, out_mon.error_code);
      error_count++;
      return;
    end
    want = expected_results.pop_front();
    check_field("result_kind", 16'(want.result_kind), 16'(out_mon.result_kind));
    check_field("record_address", want.record_address, out_mon.record_address);
    check_field("byte_index", 16'(want.byte_index), 16'(out_mon.byte_index));
    check_field("data_value", 16'(want.data_value), 16'(out_mon.data_value));
    check_field("record_kind", 16'(want.record_kind), 16'(out_mon.record_kind));
    check_field("error_code", 16'(want.error_code), 16'(out_mon.error_code));
    check_field("last_of_run", 16'(want.last_of_run), 16'(out_mon.last_of_run));
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      clear_line();
      stream_done   = 1'b0;
      stream_failed = 1'b0;
      expected_results.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) parse_char(in_mon.char_in, in_mon.end_of_input);
      if (out_mon.valid && out_mon.ready) check_result();
    end
    pending_count = expected_results.size();
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import hrsp_pkg::*;

  localparam int STALL_LIMIT = 2000;

  typedef enum int {
    END_EOF,
    END_INPUT_IDLE,
    END_INPUT_OPEN,
    END_INPUT_EOF_OPEN,
    END_PREFIX,
    END_LENGTH,
    END_HEADER_CHAR,
    END_MISMATCH,
    END_DATA_CHAR,
    END_CHECKSUM,
    END_TYPE,
    END_INNER_SPACE,
    END_GARBAGE
  } finish_t;

  logic       clk;
  logic       rst;
  int         err_count;
  int         pend_count;
  int         idle_cycles = 0;
  int         chars_sent = 0;
  bit         quiet = 1'b0;
  logic [7:0] text_q[$];
  logic [7:0] line_sum;

  hrsp_in_if  in_ch();
  hrsp_out_if out_ch();

  hex_record_stream_parser uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  hrsp_record_checker chk (
    .clk           (clk),
    .rst           (rst),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .error_count   (err_count),
    .pending_count (pend_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic logic [7:0] hex_digit(logic [3:0] n);
    if (n < 10) return "0" + n;
    if ($urandom_range(0, 1)) return 8'("A" + n - 10);
    return 8'("a" + n - 10);
  endfunction

  function automatic logic [7:0] bad_char();
    case ($urandom_range(0, 2))
      0: return 8'("g" + $urandom_range(0, 19));
      1: return 8'("G" + $urandom_range(0, 19));
      default: return 8'(8'h80 + $urandom_range(0, 127));
    endcase
  endfunction

  function automatic logic [7:0] ws_char();
    case ($urandom_range(0, 2))
      0: return CHAR_SPACE;
      1: return CHAR_TAB;
      default: return CHAR_CR;
    endcase
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [15:0] rand_addr();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic void append_char(logic [7:0] ch);
    text_q.insert(text_q.size(), ch);
  endfunction

  function automatic void add_byte(logic [7:0] b);
    append_char(hex_digit(b[7:4]));
    append_char(hex_digit(b[3:0]));
    line_sum = line_sum + b;
  endfunction

  function automatic void build_record(int count_val, int data_len, logic [15:0] a,
                                       logic [7:0] t, int fill);
    line_sum = 8'd0;
    append_char(CHAR_COLON);
    add_byte(count_val[7:0]);
    add_byte(a[15:8]);
    add_byte(a[7:0]);
    add_byte(t);
    for (int i = 0; i < data_len; i++) add_byte(fill < 0 ? rand_byte() : fill[7:0]);
    add_byte(8'd0 - line_sum);
  endfunction

  function automatic void add_random_record();
    int         c;
    logic [7:0] t;
    c = ($urandom_range(0, 49) == 0) ? 255 : $urandom_range(0, 8);
    t = ($urandom_range(0, 9) < 6) ? TYPE_DATA
                                   : 8'($urandom_range(TYPE_EOF + 1, TYPE_MAX));
    build_record(c, c, rand_addr(), t, -1);
  endfunction

  function automatic void add_tail(bit with_lf);
    int n;
    n = $urandom_range(0, 3);
    repeat (n) append_char(ws_char());
    if (with_lf) append_char(CHAR_LF);
  endfunction

  task automatic send_item(logic [7:0] c, logic eoi);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.char_in      <= c;
    in_ch.end_of_input <= eoi;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_item(text_q[i], 1'b0);
    text_q.delete();
  endtask

  task automatic finish_stream(finish_t how);
    int c;
    int d;
    int p;
    c = $urandom_range(0, 16);
    case (how)
      END_EOF: begin
        build_record(0, 0, rand_addr(), TYPE_EOF, -1);
        add_tail(1'b1);
        send_text();
      end
      END_INPUT_IDLE: begin
        add_tail(1'b0);
        send_text();
        send_item(8'($urandom_range(0, 255)), 1'b1);
      end
      END_INPUT_OPEN: begin
        add_random_record();
        add_tail(1'b0);
        send_text();
        send_item(8'($urandom_range(0, 255)), 1'b1);
      end
      END_INPUT_EOF_OPEN: begin
        build_record(0, 0, rand_addr(), TYPE_EOF, -1);
        send_text();
        send_item(8'($urandom_range(0, 255)), 1'b1);
      end
      END_PREFIX: begin
        add_random_record();
        do text_q[0] = 8'($urandom_range(33, 126)); while (text_q[0] == CHAR_COLON);
        add_tail(1'b1);
        send_text();
      end
      END_LENGTH: begin
        add_random_record();
        if ($urandom_range(0, 1)) begin
          d = $urandom_range(1, 10);
          while (text_q.size() > d) text_q.delete(text_q.size() - 1);
        end else begin
          text_q.delete(text_q.size() - 1);
        end
        add_tail(1'b1);
        send_text();
      end
      END_HEADER_CHAR: begin
        add_random_record();
        text_q[$urandom_range(1, 8)] = bad_char();
        add_tail(1'b1);
        send_text();
      end
      END_MISMATCH: begin
        if (c > 0 && $urandom_range(0, 1))
          d = $urandom_range(0, c - 1);
        else
          d = c + (($urandom_range(0, 3) == 0) ? $urandom_range(500, 520)
                                               : $urandom_range(1, 4));
        build_record(c, d, rand_addr(), TYPE_DATA, -1);
        add_tail(1'b1);
        send_text();
      end
      END_DATA_CHAR: begin
        c = $urandom_range(1, 16);
        build_record(c, c, rand_addr(), TYPE_DATA, -1);
        text_q[$urandom_range(9, text_q.size() - 1)] = bad_char();
        add_tail(1'b1);
        send_text();
      end
      END_CHECKSUM: begin
        add_random_record();
        p = text_q.size() - 1;
        text_q[p] = (text_q[p] == "0") ? "1" : "0";
        add_tail(1'b1);
        send_text();
      end
      END_TYPE: begin
        build_record(c, c, rand_addr(), 8'($urandom_range(TYPE_MAX + 1, 255)), -1);
        add_tail(1'b1);
        send_text();
      end
      END_INNER_SPACE: begin
        add_random_record();
        text_q.insert($urandom_range(1, text_q.size() - 1), ws_char());
        add_tail(1'b1);
        send_text();
      end
      default: begin
        repeat ($urandom_range(1, 40)) append_char(8'($urandom_range(0, 255)));
        add_tail(1'b1);
        send_text();
      end
    endcase
  endtask

  initial begin
    int g;
    forever begin
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      g = gap_len();
      if (g > 0) begin
        out_ch.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    finish_t how;
    rst                <= 1'b1;
    in_ch.valid        <= 1'b0;
    in_ch.char_in      <= 8'd0;
    in_ch.end_of_input <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    text_q = {CHAR_SPACE, CHAR_TAB, CHAR_CR, CHAR_LF};
    send_text();
    build_record(1, 1, 16'hFFFF, TYPE_DATA, 8'hFF);
    append_char(CHAR_CR);
    append_char(CHAR_LF);
    send_text();
    build_record(0, 0, 16'h0000, TYPE_MAX, 0);
    append_char(CHAR_LF);
    send_text();

    while (chars_sent < 1000) begin
      if ($urandom_range(0, 9) != 0) add_random_record();
      add_tail(1'b1);
      send_text();
      if ($urandom_range(0, 7) == 0) quiet = !quiet;
    end
    quiet = 1'b0;

    how = finish_t'($urandom_range(0, int'(END_GARBAGE)));
    finish_stream(how);
    // drop: everything after the stream closes
    repeat (30) send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    in_ch.valid <= 1'b0;

    wait (pend_count == 0);
    repeat (20) @(posedge clk);
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
